// ----- rtl/mbe_pkg.sv -----
// Shared types and constants for the escape-time pixel core.
package mbe_pkg;

   // View geometry and fixed-point format (Q5.58)
   localparam int IMG_WIDTH    = 256;
   localparam int IMG_HEIGHT   = 256;
   localparam int HALF_WIDTH   = IMG_WIDTH / 2;
   localparam int HALF_HEIGHT  = IMG_HEIGHT / 2;
   localparam int SHIFT_WIDTH  = $clog2(IMG_WIDTH);
   localparam int SHIFT_HEIGHT = $clog2(IMG_HEIGHT);
   localparam int FRAC_BITS    = 58;

   // Escape radius 20, compared as |z|^2 against 400 in Q13.116
   localparam int ESCAPE_RADIUS = 20;
   localparam logic [128:0] M2_LIMIT =
      129'(ESCAPE_RADIUS * ESCAPE_RADIUS) << (2 * FRAC_BITS);

   // Palette: six ramps of 130 steps each
   localparam int PALETTE_LENGTH = 780;
   localparam int RAMP_LO        = 125;
   localparam int RAMP_HI        = 255;
   localparam int SEG_LEN        = RAMP_HI - RAMP_LO;
   localparam int SEG_COUNT      = PALETTE_LENGTH / SEG_LEN;

   // Register reset values
   localparam logic [62:0] ZOOM_RESET     = 63'(64'd2 << FRAC_BITS);
   localparam logic [15:0] MAX_ITER_RESET = 16'd100;

   // Register file: 64-bit registers at 8-byte spacing
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_LSB = 3;

   typedef enum logic [1:0] {
      REG_ZOOM_SPAN = 2'd0,
      REG_CENTRE_RE = 2'd1,
      REG_CENTRE_IM = 2'd2,
      REG_MAX_ITER  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [62:0]        zoom_span;
      logic signed [63:0] centre_re;
      logic signed [63:0] centre_im;
      logic [15:0]        max_iter;
   } cfg_type;

   // Operand pair for the shared multiplier
   typedef enum logic [1:0] {
      MUL_RR,
      MUL_II,
      MUL_RI
   } mul_sel_type;

   typedef struct packed {
      logic        start;
      logic        map_mul;
      logic        map_sum;
      mul_sel_type mul_sel;
      logic        load_sr;
      logic        load_si;
      logic        step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic escaped;
      logic overflow;
      logic at_max;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [15:0] iter_count;
      logic [9:0]  palette_index;
      rgb_type     rgb;
   } result_type;

endpackage

// ----- rtl/mbe_mul64.sv -----
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module mbe_mul64
   import mbe_pkg::*;
(
   input  logic         clock,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic [127:0] product
);

   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [63:0]  p00_in, p01_in, p10_in, p11_in;
   logic [127:0] prod_ff, prod_in;

   always_comb begin
      p00_in = op_a[31:0]  * op_b[31:0];
      p01_in = op_a[31:0]  * op_b[63:32];
      p10_in = op_a[63:32] * op_b[31:0];
      p11_in = op_a[63:32] * op_b[63:32];
   end

   always_comb begin
      prod_in = {64'd0, p00_ff}
              + ({64'd0, p01_ff} << 32)
              + ({64'd0, p10_ff} << 32)
              + {p11_ff, 64'd0};
   end

   always_ff @(posedge clock) begin
      p00_ff  <= p00_in;
      p01_ff  <= p01_in;
      p10_ff  <= p10_in;
      p11_ff  <= p11_in;
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// ----- rtl/mbe_csr.sv -----
// APB-style register file holding the view and iteration limit.
module mbe_csr
   import mbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index = reg_index_type'(paddr[CSR_ADDR_W-1:CSR_ADDR_LSB]);
   assign wr_en = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_ZOOM_SPAN: cfg_in.zoom_span = pwdata[62:0];
            REG_CENTRE_RE: cfg_in.centre_re = pwdata;
            REG_CENTRE_IM: cfg_in.centre_im = pwdata;
            REG_MAX_ITER:  cfg_in.max_iter  = pwdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zoom_span <= ZOOM_RESET;
         cfg_ff.centre_re <= '0;
         cfg_ff.centre_im <= '0;
         cfg_ff.max_iter  <= MAX_ITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_ZOOM_SPAN: prdata = {1'b0, cfg_ff.zoom_span};
         REG_CENTRE_RE: prdata = cfg_ff.centre_re;
         REG_CENTRE_IM: prdata = cfg_ff.centre_im;
         REG_MAX_ITER:  prdata = {48'd0, cfg_ff.max_iter};
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/mbe_datapath.sv -----
// Datapath: coordinate mapping, z iteration, palette counters and output register.
module mbe_datapath
   import mbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   input  logic [7:0] pixel_x,
   input  logic [7:0] pixel_y,
   input  logic       rsp_ready,
   output status_type status,
   output logic       rsp_valid,
   output result_type result
);

   function automatic logic [63:0] mag(input logic [63:0] v);
      mag = v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] sat66(input logic [65:0] v);
      if (v[65:63] == 3'b000 || v[65:63] == 3'b111) begin
         sat66 = v[63:0];
      end else begin
         sat66 = v[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
   endfunction

   function automatic rgb_type palette_rgb(input logic [2:0] seg, input logic [7:0] t);
      rgb_type c;
      logic [7:0] up, down;
      up   = 8'(RAMP_LO) + t;
      down = 8'(RAMP_HI) - t;
      c    = '{red: 8'(RAMP_HI), green: 8'(RAMP_HI), blue: 8'(RAMP_HI)};
      case (seg)
         3'd0: c = '{red: up, green: 8'(RAMP_LO), blue: 8'(RAMP_LO)};
         3'd1: begin
            c.green = up;
            c.blue  = 8'(RAMP_LO);
         end
         3'd2: c.blue = up;
         3'd3: c.red  = down;
         3'd4: begin
            c.red   = 8'(RAMP_LO);
            c.green = down;
         end
         default: c = '{red: 8'(RAMP_LO), green: 8'(RAMP_LO), blue: down};
      endcase
      palette_rgb = c;
   endfunction

   // pixel and mapping
   logic [7:0]         px_ff, py_ff;
   logic signed [64:0] mx_ff, my_ff, mx_in, my_in;
   logic signed [63:0] cr_ff, ci_ff;
   logic signed [8:0]  off_x, off_y;
   logic signed [72:0] px_prod, py_prod;
   logic [65:0]        cr_wide, ci_wide;

   // iteration
   logic signed [63:0] zr_ff, zi_ff, zr_in, zi_in;
   logic [127:0]       sr_ff, si_ff;
   logic [63:0]        mul_a, mul_b;
   logic [127:0]       prod;
   logic [128:0]       diff, m2, pri;
   logic [71:0]        re_wide;
   logic [72:0]        im_wide;
   logic               re_fits, im_fits;

   // count and palette position
   logic [15:0] count_ff, count_in;
   logic [9:0]  idx_ff, idx_in;
   logic [2:0]  seg_ff, seg_in;
   logic [7:0]  t_ff, t_in;

   // output register
   result_type res_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   // mapping: floor((pix - half) * zoom / size), then add or subtract the centre
   always_comb begin
      off_x   = $signed({1'b0, px_ff} - 9'(HALF_WIDTH));
      off_y   = $signed({1'b0, py_ff} - 9'(HALF_HEIGHT));
      px_prod = off_x * $signed({1'b0, cfg.zoom_span});
      py_prod = off_y * $signed({1'b0, cfg.zoom_span});
      mx_in   = 65'(px_prod >>> SHIFT_WIDTH);
      my_in   = 65'(py_prod >>> SHIFT_HEIGHT);
      cr_wide = {mx_ff[64], mx_ff} + {{2{cfg.centre_re[63]}}, cfg.centre_re};
      ci_wide = {my_ff[64], my_ff} - {{2{cfg.centre_im[63]}}, cfg.centre_im};
   end

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_RR: begin
            mul_a = mag(zr_ff);
            mul_b = mag(zr_ff);
         end
         MUL_II: begin
            mul_a = mag(zi_ff);
            mul_b = mag(zi_ff);
         end
         MUL_RI: begin
            mul_a = mag(zr_ff);
            mul_b = mag(zi_ff);
         end
         default: begin
            mul_a = mag(zr_ff);
            mul_b = mag(zi_ff);
         end
      endcase
   end

   mbe_mul64 u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   // evaluation: prod holds |zr*zi| here
   always_comb begin
      diff    = {1'b0, sr_ff} - {1'b0, si_ff};
      m2      = {1'b0, sr_ff} + {1'b0, si_ff};
      pri     = (zr_ff[63] ^ zi_ff[63]) ? (129'd0 - {1'b0, prod}) : {1'b0, prod};
      re_wide = {diff[128], diff[128:FRAC_BITS]} + {{8{cr_ff[63]}}, cr_ff};
      im_wide = {pri[128], pri[128:FRAC_BITS-1]} + {{9{ci_ff[63]}}, ci_ff};
      re_fits = (&re_wide[71:63]) | ~(|re_wide[71:63]);
      im_fits = (&im_wide[72:63]) | ~(|im_wide[72:63]);
      zr_in   = re_wide[63:0];
      zi_in   = im_wide[63:0];
   end

   // count and palette counters advance together; idx = seg*SEG_LEN + t
   always_comb begin
      count_in = count_ff + 16'd1;
      idx_in   = (idx_ff == 10'(PALETTE_LENGTH - 1)) ? 10'd0 : idx_ff + 10'd1;
      seg_in   = seg_ff;
      t_in     = t_ff + 8'd1;
      if (t_ff == 8'(SEG_LEN - 1)) begin
         t_in   = 8'd0;
         seg_in = (seg_ff == 3'(SEG_COUNT - 1)) ? 3'd0 : seg_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff    <= pixel_x;
         py_ff    <= pixel_y;
         zr_ff    <= '0;
         zi_ff    <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         seg_ff   <= '0;
         t_ff     <= '0;
      end else if (cmd.step) begin
         zr_ff    <= zr_in;
         zi_ff    <= zi_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         seg_ff   <= seg_in;
         t_ff     <= t_in;
      end
      if (cmd.map_mul) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
      end
      if (cmd.map_sum) begin
         cr_ff <= sat66(cr_wide);
         ci_ff <= sat66(ci_wide);
      end
      if (cmd.load_sr) begin
         sr_ff <= prod;
      end
      if (cmd.load_si) begin
         si_ff <= prod;
      end
      if (cmd.out_load) begin
         res_ff.iter_count    <= count_ff;
         res_ff.palette_index <= idx_ff;
         res_ff.rgb           <= palette_rgb(seg_ff, t_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.escaped  = (m2 >= M2_LIMIT);
   assign status.overflow = ~(re_fits & im_fits);
   assign status.at_max   = (count_ff >= cfg.max_iter);
   assign status.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign result    = res_ff;

endmodule

// ----- rtl/mbe_ctrl.sv -----
// Sequencer for mapping, the iteration loop and result hand-off.
module mbe_ctrl
   import mbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_MUL,
      ST_MAP_SUM,
      ST_MUL_RR,
      ST_MUL_II,
      ST_MUL_RI,
      ST_WAIT,
      ST_EVAL,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MAP_MUL;
         ST_MAP_MUL: state_in = ST_MAP_SUM;
         ST_MAP_SUM: state_in = ST_MUL_RR;
         ST_MUL_RR:  state_in = ST_MUL_II;
         ST_MUL_II:  state_in = ST_MUL_RI;
         ST_MUL_RI:  state_in = ST_WAIT;
         ST_WAIT:    state_in = ST_EVAL;
         ST_EVAL: begin
            // escape test on current z and the limit first, then overflow, else a step
            priority if (status.escaped || status.at_max) begin
               state_in = ST_DONE;
            end else if (status.overflow) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL_RR;
            end
         end
         ST_DONE:    if (status.out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_RR;
      cmd.start    = (state_ff == ST_IDLE) & req_valid;
      cmd.map_mul  = (state_ff == ST_MAP_MUL);
      cmd.map_sum  = (state_ff == ST_MAP_SUM);
      cmd.load_sr  = (state_ff == ST_MUL_RI);
      cmd.load_si  = (state_ff == ST_WAIT);
      cmd.step     = (state_ff == ST_EVAL) & ~status.escaped & ~status.at_max;
      cmd.out_load = (state_ff == ST_DONE) & status.out_free;
      unique case (state_ff)
         ST_MUL_II: cmd.mul_sel = MUL_II;
         ST_MUL_RI: cmd.mul_sel = MUL_RI;
         default:   cmd.mul_sel = MUL_RR;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ----- rtl/mandelbrot_escape_time_pixel_core.sv -----
// Top level of the escape-time pixel core: register file, sequencer and datapath.
//
// Use:
//   req_*  : one beat per pixel, tdata = {pixel_y, pixel_x}.
//   rsp_*  : one beat per pixel with its iteration count, palette index
//            (count mod 780) and RGB from the grey/red/yellow/white/cyan/blue ramp.
//   csr_*  : APB-style registers, 64-bit data, at 0x00 zoom_span, 0x08
//            centre_re, 0x10 centre_im, 0x18 max_iter. Write only while idle.
// Timing:
//   One pixel at a time. After acceptance, the MAP_MUL and MAP_SUM states map the
//   pixel to c, then each pass of the loop issues three products (zr^2, zi^2,
//   zr*zi) back to back into the shared 2-stage 64x64 multiplier, then passes
//   through a wait state and an evaluate state. The loop ends when z escapes,
//   the count reaches max_iter or z leaves Q5.58, and the result is then
//   loaded. req_tready rises the cycle after load.
// Reset: synchronous; registers return to zoom 2.0, centre 0, limit 100,
//   any pixel in flight is dropped and rsp_tvalid clears.
// Stall: the result sits in the output register; the next pixel is taken
//   and computed meanwhile, and waits for the register before its load.
module mandelbrot_escape_time_pixel_core
   import mbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // pixel requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [7:0] pixel_x, [15:8] pixel_y
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,   // [15:0] iter_count, [25:16] palette_index,
                                              // [33:26] red, [41:34] green, [49:42] blue,
                                              // [55:50] zero
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   result_type result;

   // no wait states on the register port
   assign csr_pready = 1'b1;

   mbe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mbe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .pixel_x   (req_tdata[7:0]),
      .pixel_y   (req_tdata[15:8]),
      .rsp_ready (rsp_tready),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .result    (result)
   );

   // pack result fields, lowest field in the lowest bits
   assign rsp_tdata = {6'd0, result.rgb.blue, result.rgb.green, result.rgb.red,
                       result.palette_index, result.iter_count};

endmodule

// ----- rtl/mbe_checker.sv -----
// Port-level checks for the escape-time pixel core, bound to the top level.
module mbe_checker
   import mbe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // a held result beat keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one pixel at a time: accepting a beat makes the core busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a pixel is in flight");

   // palette index matches the count below one palette length
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:0] < 16'(PALETTE_LENGTH))
      |-> rsp_tdata[25:16] == rsp_tdata[9:0])
      else $error("palette index differs from short count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:16] < 10'(PALETTE_LENGTH))
      else $error("palette index out of range");

   // every color channel stays at or above the ramp floor
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:26] >= 8'(RAMP_LO)) && (rsp_tdata[41:34] >= 8'(RAMP_LO))
                  && (rsp_tdata[49:42] >= 8'(RAMP_LO)))
      else $error("color channel below ramp floor");

endmodule

bind mandelbrot_escape_time_pixel_core mbe_checker u_checker (.*);
